// ----- design/ipss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipss_pkg
// Shared types and constants of the IOMMU page size splitter.
// ----------------------------------------------------------------------------
package ipss_pkg;

  localparam int FIELD_W     = 48;
  localparam int DW          = FIELD_W + 1;
  localparam int MASK_W      = 44;
  localparam int MASK_LO     = 12;
  localparam int SHIFT_W     = 6;
  localparam int COUNT_W     = 37;
  localparam int RES_W       = 6;
  localparam int MAX_RESULTS = 63;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [MASK_W-1:0] MASK_RESET = MASK_W'(4096);

  typedef struct packed {
    logic [FIELD_W-1:0] virt_addr;
    logic [FIELD_W-1:0] phys_addr;
    logic [FIELD_W-1:0] region_bytes;
    logic               misaligned;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- design/ipss_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipss_fifo
// Small register queue between the request front and the split engine.
// ----------------------------------------------------------------------------
module ipss_fifo import ipss_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output q_stat_t          stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ----- design/ipss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipss_front
// Accepts map requests, checks alignment and drops empty ones.
// ----------------------------------------------------------------------------
module ipss_front import ipss_pkg::*; #(
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_virt_addr,
  input  logic [FIELD_W-1:0] in_phys_addr,
  input  logic [FIELD_W-1:0] in_region_bytes,
  input  logic [MASK_W-1:0]  page_mask,
  input  q_stat_t            q_stat,
  output logic               q_push,
  output req_t               q_req
);

  localparam int AW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam logic [FIELD_W:0] FMASK_W = ({{FIELD_W{1'b0}}, 1'b1} << AW) - 1'b1;
  localparam logic [FIELD_W-1:0] FMASK = FMASK_W[FIELD_W-1:0];

  logic               valid_r;
  req_t               req_r;
  logic               accept;
  logic [MASK_W-1:0]  mask_used;
  logic [MASK_W-1:0]  low_bit;
  logic [FIELD_W-1:0] below;
  logic               err;

  assign busy   = valid_r && q_stat.full;
  assign accept = start && !busy;

  always_comb begin
    mask_used = page_mask & ~MASK_W'((1 << MASK_LO) - 1);
    low_bit   = mask_used & (~mask_used + 1'b1);
    below     = {{(FIELD_W - MASK_W){1'b0}}, low_bit - 1'b1};
    err       = (mask_used == '0) ||
                (((req_r.virt_addr | req_r.phys_addr | req_r.region_bytes) & below) != '0);
    q_req            = req_r;
    q_req.misaligned = err;
    q_push           = valid_r && !q_stat.full && (err || (req_r.region_bytes != '0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (valid_r && !q_stat.full) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.virt_addr    <= in_virt_addr & FMASK;
      req_r.phys_addr    <= in_phys_addr & FMASK;
      req_r.region_bytes <= in_region_bytes & FMASK;
      req_r.misaligned   <= 1'b0;
    end
  end

endmodule

// ----- design/ipss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipss_back
// Split engine: cuts one request into chunks, four steps per chunk.
// ----------------------------------------------------------------------------
module ipss_back import ipss_pkg::*; #(
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [MASK_W-1:0]  page_mask,
  input  q_stat_t            q_stat,
  input  req_t               q_req,
  output logic               q_pop,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_chunk_virt,
  output logic [FIELD_W-1:0] out_chunk_phys,
  output logic [SHIFT_W-1:0] out_page_shift,
  output logic [COUNT_W-1:0] out_page_count,
  output logic [FIELD_W-1:0] out_bytes_done,
  output logic               out_misaligned,
  output logic               out_last_chunk
);

  localparam int AW = (ADDR_BITS < FIELD_W) ? ADDR_BITS : FIELD_W;
  localparam logic [DW:0] AMASK_W = ({{DW{1'b0}}, 1'b1} << AW) - 1'b1;
  localparam logic [DW-1:0] AMASK = AMASK_W[DW-1:0];
  localparam logic [DW-1:0] ONE = DW'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_SIZES,
    S_IDX,
    S_SPAN,
    S_EMIT
  } state_t;

  state_t             state_r;
  logic [DW-1:0]      v_r;
  logic [DW-1:0]      p_r;
  logic [DW-1:0]      rem_r;
  logic [DW-1:0]      done_r;
  logic [RES_W-1:0]   k_r;
  logic [DW-1:0]      sizes_r;
  logic [SHIFT_W-1:0] idx_r;
  logic [DW-1:0]      span_r;

  logic [DW-1:0]      mask_x;
  logic [DW-1:0]      merge;
  logic [DW-1:0]      smear;
  logic [DW-1:0]      sizes_nxt;
  logic [SHIFT_W-1:0] idx_nxt;
  logic [DW-1:0]      span_nxt;
  logic [DW-1:0]      up_to_idx;
  logic [DW-1:0]      higher;
  logic [DW-1:0]      nxt_pg;
  logic [DW-1:0]      off;
  logic [DW-1:0]      below_idx;
  logic [DW-1:0]      cnt;
  logic [DW-1:0]      sz;
  logic [DW-1:0]      rem_left;
  logic               last;

  assign q_pop = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    mask_x = {{(DW - MASK_W){1'b0}}, page_mask & ~MASK_W'((1 << MASK_LO) - 1)};
    merge  = v_r | p_r;

    smear = rem_r;
    for (int i = 0; i < 6; i++) begin
      smear = smear | (smear >> (1 << i));
    end
    sizes_nxt = mask_x & smear & (merge ^ (merge - 1'b1));

    idx_nxt = '0;
    for (int i = 0; i < DW; i++) begin
      if (sizes_r[i]) begin
        idx_nxt = SHIFT_W'(i);
      end
    end

    below_idx = (ONE << idx_r) - 1'b1;
    up_to_idx = below_idx | (ONE << idx_r);
    higher    = mask_x & ~up_to_idx;
    nxt_pg    = higher & (~higher + 1'b1);
    off       = nxt_pg - (merge & (nxt_pg - 1'b1));
    span_nxt  = rem_r;
    if ((higher != '0) && (((v_r ^ p_r) & (nxt_pg - 1'b1)) == '0) &&
        ((off + nxt_pg) <= rem_r)) begin
      span_nxt = off;
    end

    cnt      = span_r >> idx_r;
    sz       = span_r & ~below_idx;
    rem_left = rem_r - sz;
    last     = (rem_left == '0) || (k_r == RES_W'(MAX_RESULTS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (!q_stat.empty) begin
            state_r <= q_req.misaligned ? S_ERR : S_SIZES;
          end
        end
        S_ERR: begin
          out_valid <= 1'b1;
          state_r   <= S_IDLE;
        end
        S_SIZES: begin
          out_valid <= 1'b0;
          state_r   <= S_IDX;
        end
        S_IDX: begin
          out_valid <= 1'b0;
          state_r   <= (sizes_r == '0) ? S_IDLE : S_SPAN;
        end
        S_SPAN: begin
          out_valid <= 1'b0;
          state_r   <= S_EMIT;
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          state_r   <= last ? S_IDLE : S_SIZES;
        end
        default: begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        v_r    <= {1'b0, q_req.virt_addr};
        p_r    <= {1'b0, q_req.phys_addr};
        rem_r  <= {1'b0, q_req.region_bytes};
        done_r <= '0;
        k_r    <= '0;
      end
      S_ERR: begin
        out_chunk_virt <= v_r[FIELD_W-1:0];
        out_chunk_phys <= p_r[FIELD_W-1:0];
        out_page_shift <= '0;
        out_page_count <= '0;
        out_bytes_done <= '0;
        out_misaligned <= 1'b1;
        out_last_chunk <= 1'b1;
      end
      S_SIZES: begin
        sizes_r <= sizes_nxt;
      end
      S_IDX: begin
        idx_r <= idx_nxt;
      end
      S_SPAN: begin
        span_r <= span_nxt;
      end
      S_EMIT: begin
        out_chunk_virt <= v_r[FIELD_W-1:0];
        out_chunk_phys <= p_r[FIELD_W-1:0];
        out_page_shift <= idx_r;
        out_page_count <= cnt[COUNT_W-1:0];
        out_bytes_done <= done_r[FIELD_W-1:0] + sz[FIELD_W-1:0];
        out_misaligned <= 1'b0;
        out_last_chunk <= last;
        done_r <= done_r + sz;
        rem_r  <= rem_left;
        v_r    <= (v_r + sz) & AMASK;
        p_r    <= (p_r + sz) & AMASK;
        k_r    <= k_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/iommu_page_size_splitter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iommu_page_size_splitter_unit
// Splits a map request into chunks of the largest usable page sizes.
// Each chunk passes the size mask, encode, span and emit steps; each request
// is first popped from the two-word queue.
// Reset: synchronous; clears control and sets page_mask_r to 4 KiB only.
// Results are strobed for one cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
module iommu_page_size_splitter_unit import ipss_pkg::*; #(
  parameter int ADDR_BITS = 48
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] in_virt_addr,
  input  logic [FIELD_W-1:0] in_phys_addr,
  input  logic [FIELD_W-1:0] in_region_bytes,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [MASK_W-1:0]  cfg_data,
  output logic               out_valid,
  output logic [FIELD_W-1:0] out_chunk_virt,
  output logic [FIELD_W-1:0] out_chunk_phys,
  output logic [SHIFT_W-1:0] out_page_shift,
  output logic [COUNT_W-1:0] out_page_count,
  output logic [FIELD_W-1:0] out_bytes_done,
  output logic               out_misaligned,
  output logic               out_last_chunk
);

  logic [MASK_W-1:0] page_mask_r;
  q_stat_t           q_stat;
  logic              q_push;
  logic              q_pop;
  req_t              q_wr;
  req_t              q_rd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_mask_r <= MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      page_mask_r <= cfg_data;
    end
  end

  ipss_front #(
    .ADDR_BITS(ADDR_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_virt_addr   (in_virt_addr),
    .in_phys_addr   (in_phys_addr),
    .in_region_bytes(in_region_bytes),
    .page_mask      (page_mask_r),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_req          (q_wr)
  );

  ipss_fifo #(
    .WIDTH($bits(req_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(q_wr),
    .pop    (q_pop),
    .rd_data(q_rd),
    .stat   (q_stat)
  );

  ipss_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .page_mask     (page_mask_r),
    .q_stat        (q_stat),
    .q_req         (q_rd),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_chunk_virt(out_chunk_virt),
    .out_chunk_phys(out_chunk_phys),
    .out_page_shift(out_page_shift),
    .out_page_count(out_page_count),
    .out_bytes_done(out_bytes_done),
    .out_misaligned(out_misaligned),
    .out_last_chunk(out_last_chunk)
  );

endmodule
